### design/sog_pkg.sv
package sog_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned TARGET_BITS = 31;
  localparam int unsigned LENGTH_BITS = 13;
  localparam int unsigned GAIN_BITS   = 24;
  localparam int unsigned GAIN_FRAC   = 21;
  localparam int unsigned ROUND_HALF  = 1 << (GAIN_FRAC - 1);

  // Default geometry.
  localparam int unsigned DEF_PHASE_BITS      = 32;
  localparam int unsigned DEF_TABLE_ADDR_BITS = 10;
  localparam int unsigned DEF_SAMPLE_BITS     = 16;
  localparam int unsigned DEF_MAX_BLOCK       = 4096;

  // Phase step after reset: 1 Hz at 48 kHz with a 32-bit accumulator.
  localparam logic [63:0] RESET_STEP = 64'd89478;

  // Command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Quarter wave sine generator constants (Q30).
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_LOOK,
    BK_MUL,
    BK_OUT
  } sog_back_state_t;

  // What the front reports about the head of its queue.
  typedef struct packed {
    logic not_empty;
    logic is_start;
  } sog_q_stat_t;

  // Magnitude of sin(pi/2 * q / 2^qbits) scaled to 2^(sbits-1)-1, from a
  // eleventh order Taylor series in Q30. Evaluated on constants only.
  function automatic logic [31:0] sine_quarter(int unsigned q, int unsigned qbits,
                                               int unsigned sbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] full;
    logic [63:0] mag;
    logic signed [63:0] sum;
    x    = (64'(q) * HALF_PI_Q30) >> qbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int k = 1; k <= 5; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if ((k % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > $signed(ONE_Q30)) begin
      sum = $signed(ONE_Q30);
    end
    full = (64'd1 << (sbits - 1)) - 64'd1;
    mag  = (64'(sum) * full + (ONE_Q30 >> 1)) >> 30;
    if (mag > full) begin
      mag = full;
    end
    return mag[31:0];
  endfunction

endpackage

### design/sog_div.sv
module sog_div import sog_pkg::*; #(
  parameter int unsigned PHASE_BITS = DEF_PHASE_BITS,
  parameter int unsigned LEN_BITS   = $clog2(DEF_MAX_BLOCK + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [PHASE_BITS-1:0] num,
  input  logic [LEN_BITS-1:0]   den,
  output logic                  done,
  output logic [PHASE_BITS-1:0] quo
);

  localparam int unsigned CW = $clog2(PHASE_BITS + 1);

  // Restoring division, one quotient bit per cycle.
  logic [LEN_BITS-1:0] rem;
  logic [LEN_BITS-1:0] den_r;
  logic [CW-1:0]       cnt;
  logic                busy;
  logic [LEN_BITS:0]   shifted;
  logic [LEN_BITS:0]   diff;
  logic                ge;

  assign shifted = {rem, quo[PHASE_BITS-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      cnt   <= CW'(PHASE_BITS);
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? diff[LEN_BITS-1:0] : shifted[LEN_BITS-1:0];
      quo <= {quo[PHASE_BITS-2:0], ge};
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

### design/sog_front.sv
module sog_front import sog_pkg::*; #(
  parameter int unsigned PHASE_BITS = DEF_PHASE_BITS,
  parameter int unsigned MAX_BLOCK  = DEF_MAX_BLOCK,
  parameter int unsigned LEN_BITS   = $clog2(DEF_MAX_BLOCK + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   block_start,
  input  logic [TARGET_BITS-1:0] target_step,
  input  logic [LENGTH_BITS-1:0] block_length,
  input  logic [GAIN_BITS-1:0]   gain,
  output sog_q_stat_t            q_stat,
  input  logic                   q_pop,
  output logic [PHASE_BITS-1:0]  q_target,
  output logic [LEN_BITS-1:0]    q_len,
  output logic [GAIN_BITS-1:0]   q_gain
);

  logic                  ent_start  [QUEUE_DEPTH];
  logic [PHASE_BITS-1:0] ent_target [QUEUE_DEPTH];
  logic [LEN_BITS-1:0]   ent_len    [QUEUE_DEPTH];
  logic [GAIN_BITS-1:0]  ent_gain   [QUEUE_DEPTH];

  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 push;
  logic [63:0]          tgt_wide;
  logic [31:0]          len_wide;
  logic [31:0]          len_clamped;

  assign in_ready = count < QCNT_BITS'(QUEUE_DEPTH);
  assign push     = in_valid && in_ready;

  // Normalize the item on the way in: mask the target to the phase width
  // and bring the length into 1..MAX_BLOCK.
  assign tgt_wide = 64'(target_step);
  assign len_wide = 32'(block_length);

  always_comb begin
    priority if (len_wide == 32'd0) begin
      len_clamped = 32'd1;
    end else if (len_wide > 32'(MAX_BLOCK)) begin
      len_clamped = 32'(MAX_BLOCK);
    end else begin
      len_clamped = len_wide;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_start[wr_ptr]  <= block_start;
      ent_target[wr_ptr] <= tgt_wide[PHASE_BITS-1:0];
      ent_len[wr_ptr]    <= len_clamped[LEN_BITS-1:0];
      ent_gain[wr_ptr]   <= gain;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_BITS'(push) - QCNT_BITS'(q_pop);
    end
  end

  assign q_stat.not_empty = count != '0;
  assign q_stat.is_start  = ent_start[rd_ptr];
  assign q_target         = ent_target[rd_ptr];
  assign q_len            = ent_len[rd_ptr];
  assign q_gain           = ent_gain[rd_ptr];

endmodule

### design/sog_back.sv
module sog_back import sog_pkg::*; #(
  parameter int unsigned PHASE_BITS      = DEF_PHASE_BITS,
  parameter int unsigned TABLE_ADDR_BITS = DEF_TABLE_ADDR_BITS,
  parameter int unsigned SAMPLE_BITS     = DEF_SAMPLE_BITS,
  parameter int unsigned LEN_BITS        = $clog2(DEF_MAX_BLOCK + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sog_q_stat_t            q_stat,
  output logic                   q_pop,
  input  logic [PHASE_BITS-1:0]  q_target,
  input  logic [LEN_BITS-1:0]    q_len,
  input  logic [GAIN_BITS-1:0]   q_gain,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [TARGET_BITS-1:0] initial_step,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] sample,
  output logic                   block_end
);

  localparam int unsigned QB = TABLE_ADDR_BITS - 2;
  localparam int unsigned QS = 1 << QB;
  localparam int unsigned MB = SAMPLE_BITS - 1;
  localparam int unsigned FS = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int unsigned PW = MB + GAIN_BITS;
  localparam int unsigned RW = PW - GAIN_FRAC + 1;

  sog_back_state_t state, state_next;

  // Architectural oscillator state.
  logic [PHASE_BITS-1:0] phase_acc;
  logic [PHASE_BITS-1:0] phase_step;
  logic [PHASE_BITS-1:0] step_delta;
  logic [PHASE_BITS-1:0] held_target;
  logic [LEN_BITS-1:0]   samples_left;
  logic [GAIN_BITS-1:0]  held_gain;

  // Per-item working registers.
  logic [LEN_BITS-1:0]   len_r;
  logic                  div_neg;
  logic [MB-1:0]         rom_val;
  logic                  quad_neg;
  logic                  neg;
  logic [PW-1:0]         prod;

  logic                  div_start;
  logic                  div_done;
  logic [PHASE_BITS-1:0] div_quo;
  logic [PHASE_BITS:0]   diff;
  logic [PHASE_BITS-1:0] diff_mag;
  logic                  out_free;
  logic                  out_load;
  logic                  cfg_write;
  logic [63:0]           cfg_wide;

  // Quarter-wave sine table, constant.
  logic [MB-1:0] rom_q [QS+1];
  for (genvar gi = 0; gi <= QS; gi++) begin : g_rom
    assign rom_q[gi] = MB'(sine_quarter(gi, QB, SAMPLE_BITS));
  end

  logic [TABLE_ADDR_BITS-1:0] idx;
  logic [QB:0]                rom_addr;

  assign idx      = phase_acc[PHASE_BITS-1 -: TABLE_ADDR_BITS];
  assign rom_addr = idx[TABLE_ADDR_BITS-2] ? ((QB+1)'(QS) - {1'b0, idx[QB-1:0]})
                                           : {1'b0, idx[QB-1:0]};

  // Step change numerator: target minus current step, as sign and magnitude.
  assign diff     = {1'b0, q_target} - {1'b0, phase_step};
  assign diff_mag = diff[PHASE_BITS] ? PHASE_BITS'(-diff) : diff[PHASE_BITS-1:0];

  sog_div #(
    .PHASE_BITS(PHASE_BITS),
    .LEN_BITS  (LEN_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (diff_mag),
    .den  (q_len),
    .done (div_done),
    .quo  (div_quo)
  );

  // Rounding and saturation of the product.
  logic [PW:0]            rnd_sum;
  logic [RW-1:0]          rounded;
  logic [SAMPLE_BITS-1:0] limit;
  logic [SAMPLE_BITS-1:0] sat;
  logic [SAMPLE_BITS-1:0] samp;

  assign rnd_sum = {1'b0, prod} + (PW+1)'(ROUND_HALF);
  assign rounded = rnd_sum[PW:GAIN_FRAC];
  assign limit   = neg ? SAMPLE_BITS'(FS + 1) : SAMPLE_BITS'(FS);
  assign sat     = (rounded > RW'(limit)) ? limit : rounded[SAMPLE_BITS-1:0];
  assign samp    = neg ? -sat : sat;

  assign out_free  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign cfg_wide  = 64'(initial_step);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_stat.not_empty) begin
          state_next = q_stat.is_start ? BK_DIV : BK_LOOK;
        end
      end
      BK_DIV: begin
        if (div_done) begin
          state_next = BK_LOOK;
        end
      end
      BK_LOOK: state_next = BK_MUL;
      BK_MUL:  state_next = BK_OUT;
      BK_OUT: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state == BK_IDLE) && q_stat.not_empty;
    div_start = q_pop && q_stat.is_start;
    out_load  = (state == BK_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc    <= '0;
      phase_step   <= RESET_STEP[PHASE_BITS-1:0];
      step_delta   <= '0;
      held_target  <= RESET_STEP[PHASE_BITS-1:0];
      samples_left <= '0;
      held_gain    <= '0;
    end else if (cfg_write) begin
      phase_step   <= cfg_wide[PHASE_BITS-1:0];
      held_target  <= cfg_wide[PHASE_BITS-1:0];
      step_delta   <= '0;
      samples_left <= '0;
    end else begin
      if (div_start) begin
        held_target <= q_target;
        held_gain   <= q_gain;
      end
      if ((state == BK_DIV) && div_done) begin
        step_delta   <= div_neg ? -div_quo : div_quo;
        samples_left <= len_r;
      end
      if (out_load) begin
        phase_acc <= phase_acc + phase_step;
        if (samples_left != '0) begin
          samples_left <= samples_left - 1'b1;
          if (samples_left == LEN_BITS'(1)) begin
            phase_step <= held_target;
            step_delta <= '0;
          end else begin
            phase_step <= phase_step + step_delta;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      len_r   <= q_len;
      div_neg <= diff[PHASE_BITS];
    end
    if (state == BK_LOOK) begin
      rom_val  <= rom_q[rom_addr];
      quad_neg <= idx[TABLE_ADDR_BITS-1];
    end
    if (state == BK_MUL) begin
      prod <= PW'(rom_val) * PW'(held_gain);
      neg  <= quad_neg && (rom_val != '0);
    end
    if (out_load) begin
      sample    <= samp;
      block_end <= samples_left == LEN_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### design/sine_oscillator_with_glide_core.sv
// Direct digital synthesis sine oscillator with linear frequency glide. Each
// accepted input item yields exactly one sample. An item with block_start set
// loads a new target phase step, block length and Q3.21 gain; the per-sample
// step change (target minus current step, divided by the length and truncated
// toward zero) is then worked out by a restoring divider that produces one
// quotient bit per clock. A plain item passes through the back end states in
// order: BK_IDLE picks it from the queue, BK_LOOK reads the sine table,
// BK_MUL does the gain multiply and BK_OUT rounds, saturates and registers
// the sample; a block start item also waits in BK_DIV, after BK_IDLE, until
// the divider is done. The front end holds up to two items in its queue and the
// sample sits in an output register, so input and output stall independently.
// The initial_step register is written through its own channel, which is
// always ready; a write reloads the step and target, clears the step change
// and ends any running block. After reset the gain is zero and the output is
// silent until the first block start.
module sine_oscillator_with_glide_core import sog_pkg::*; #(
  parameter int unsigned PHASE_BITS      = DEF_PHASE_BITS,
  parameter int unsigned TABLE_ADDR_BITS = DEF_TABLE_ADDR_BITS,
  parameter int unsigned SAMPLE_BITS     = DEF_SAMPLE_BITS,
  parameter int unsigned MAX_BLOCK       = DEF_MAX_BLOCK
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [TARGET_BITS-1:0] initial_step,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   block_start,
  input  logic [TARGET_BITS-1:0] target_step,
  input  logic [LENGTH_BITS-1:0] block_length,
  input  logic [GAIN_BITS-1:0]   gain,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] sample,
  output logic                   block_end
);

  // Samples left in a block need to reach MAX_BLOCK.
  localparam int unsigned LEN_BITS = $clog2(MAX_BLOCK + 1);

  sog_q_stat_t           q_stat;
  logic                  q_pop;
  logic [PHASE_BITS-1:0] q_target;
  logic [LEN_BITS-1:0]   q_len;
  logic [GAIN_BITS-1:0]  q_gain;

  // Front end: takes items, normalizes target and length, queues them.
  sog_front #(
    .PHASE_BITS(PHASE_BITS),
    .MAX_BLOCK (MAX_BLOCK),
    .LEN_BITS  (LEN_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .block_start (block_start),
    .target_step (target_step),
    .block_length(block_length),
    .gain        (gain),
    .q_stat      (q_stat),
    .q_pop       (q_pop),
    .q_target    (q_target),
    .q_len       (q_len),
    .q_gain      (q_gain)
  );

  // Back end: oscillator state, divider, sine table, gain and output register.
  sog_back #(
    .PHASE_BITS     (PHASE_BITS),
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .LEN_BITS       (LEN_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .q_pop       (q_pop),
    .q_target    (q_target),
    .q_len       (q_len),
    .q_gain      (q_gain),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .initial_step(initial_step),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample      (sample),
    .block_end   (block_end)
  );

endmodule

### design/sog_check.sv
module sog_check import sog_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   block_start,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] sample,
  input logic                   block_end
);

  // Items in flight: two in the queue, one in the back end, one at the output.
  localparam int unsigned MAX_FLIGHT = QUEUE_DEPTH + 2;

  logic [2:0] in_flight;
  logic       in_acc;
  logic       out_acc;
  logic       started;
  logic       armed;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
      started   <= 1'b0;
      armed     <= 1'b0;
    end else begin
      in_flight <= in_flight + 3'(in_acc) - 3'(out_acc);
      if (in_acc && block_start) begin
        started <= 1'b1;
        armed   <= 1'b1;
      end else if (cfg_valid && cfg_ready) begin
        armed <= 1'b0;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(block_end))
    else $error("output item changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_flight != 3'd0)
    else $error("result item without an accepted input item");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    in_flight <= 3'(MAX_FLIGHT))
    else $error("more items in flight than the design can hold");

  a_end_needs_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && block_end |-> armed)
    else $error("block end flagged with no block started");

  a_silent_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && !started |-> sample == '0)
    else $error("nonzero sample before the first block start");

endmodule

bind sine_oscillator_with_glide_core sog_check #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_sog_check (
  .clk        (clk),
  .rst        (rst),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .block_start(block_start),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .sample     (sample),
  .block_end  (block_end)
);
